@@ rtl/qtl_pkg.sv @@
// ----------------------------------------------------------------------------
// qtl_pkg: shared types and constants of the Q-table learner
// Field widths, operation codes, register indexes, the multiply-accumulate
// control bundle and the index reduction helper.
// ----------------------------------------------------------------------------
`default_nettype none

package qtl_pkg;

	// default table geometry
	localparam int unsigned STATE_COUNT_DEF  = 64;
	localparam int unsigned ACTION_COUNT_DEF = 4;

	// Q8.8 table entry width
	localparam int unsigned Q_W = 16;

	// multiply-accumulate widths: rate operand, value operand, accumulator
	localparam int unsigned MUL_A_W = 10;
	localparam int unsigned MUL_B_W = 25;
	localparam int unsigned ACC_W   = 35;

	// rate of one in Q1.8
	localparam logic [8:0] RATE_ONE = 9'd256;

	// operation codes
	localparam logic [1:0] OP_SELECT = 2'd0;
	localparam logic [1:0] OP_UPDATE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_LEARN_RATE    = 2'd0;
	localparam logic [1:0] REG_DISCOUNT      = 2'd1;
	localparam logic [1:0] REG_EXPLORE_LEVEL = 2'd2;

	// register reset values
	localparam logic [8:0]  LEARN_RATE_RST    = 9'd26;
	localparam logic [8:0]  DISCOUNT_RST      = 9'd230;
	localparam logic [15:0] EXPLORE_LEVEL_RST = 16'd6554;

	// control of the shared multiply-accumulate unit
	typedef struct packed {
		logic en;     // load the accumulator this cycle
		logic accum;  // add to the accumulator instead of the addend
	} mac_ctl_t;

	// Reduce a small index modulo n by binary-weighted conditional subtracts.
	function automatic logic [5:0] reduce_idx(input logic [5:0] v, input int unsigned n);
		logic [5:0] r;
		r = v;
		for (int k = 5; k >= 0; k--) begin
			if ({26'd0, r} >= (n << k)) begin
				r = r - 6'(n << k);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

@@ rtl/qtl_table.sv @@
// ----------------------------------------------------------------------------
// qtl_table: Q-value storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_table #(
	parameter int unsigned DEPTH = qtl_pkg::STATE_COUNT_DEF * qtl_pkg::ACTION_COUNT_DEF
) (
	input  wire                            clk,
	input  wire                            we,
	input  wire  [$clog2(DEPTH)-1:0]       waddr,
	input  wire  [qtl_pkg::Q_W-1:0]        wdata,
	input  wire  [$clog2(DEPTH)-1:0]       raddr,
	output logic [qtl_pkg::Q_W-1:0]        rdata
);

	logic [qtl_pkg::Q_W-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ rtl/qtl_mac.sv @@
// ----------------------------------------------------------------------------
// qtl_mac: shared multiply-accumulate unit
// acc <= (accum ? acc : addend) + a * b, signed, one product per cycle while en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module qtl_mac (
	input  wire                                  clk,
	input  wire  qtl_pkg::mac_ctl_t              ctl,
	input  wire  signed [qtl_pkg::MUL_A_W-1:0]   mul_a,
	input  wire  signed [qtl_pkg::MUL_B_W-1:0]   mul_b,
	input  wire  signed [qtl_pkg::ACC_W-1:0]     addend,
	output logic signed [qtl_pkg::ACC_W-1:0]     acc
);

	logic signed [qtl_pkg::ACC_W-1:0] prod;
	logic signed [qtl_pkg::ACC_W-1:0] base;
	logic signed [qtl_pkg::ACC_W-1:0] acc_q;

	// product and accumulate select
	assign prod = qtl_pkg::ACC_W'(mul_a * mul_b);
	assign base = ctl.accum ? acc_q : addend;

	always_ff @(posedge clk) begin
		if (ctl.en) begin
			acc_q <= base + prod;
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

@@ rtl/q_table_learner.sv @@
// ----------------------------------------------------------------------------
// q_table_learner: tabular Q-learning engine with epsilon-greedy selection
// Q table in signed Q8.8, select / update / clear commands, one result each.
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low; its result appears
// for exactly one cycle with done high and the receiver cannot stall it, so
// capture it on that cycle. A select reads the table once per action, then
// makes the last compare; an update scans the next state for its argmax, reads
// the old value, makes three passes through the single multiply-accumulate
// unit and writes back; a clear zeroes one table entry per cycle; and an
// unknown operation gives an all-zero result the cycle after transfer. After
// reset the same clearing pass runs over the whole table with busy high. A new
// command may transfer on the cycle that done is high. Configuration writes
// are taken on any cycle and should be made while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_learner #(
	parameter int unsigned STATE_COUNT  = qtl_pkg::STATE_COUNT_DEF,
	parameter int unsigned ACTION_COUNT = qtl_pkg::ACTION_COUNT_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	// command channel
	input  wire                start,
	output logic               busy,
	input  wire  [1:0]         action,
	input  wire  [5:0]         state_index,
	input  wire  [1:0]         act_index,
	input  wire  [5:0]         next_state_index,
	input  wire  signed [15:0] reward_value,
	input  wire  [15:0]        explore_draw,
	input  wire  [1:0]         random_action,
	// result channel
	output logic               done,
	output logic [1:0]         chosen_action,
	output logic               explored,
	output logic signed [15:0] q_result,
	// configuration
	input  wire                cfg_write,
	input  wire  [1:0]         cfg_index,
	input  wire  [15:0]        cfg_data
);

	localparam int unsigned DEPTH = STATE_COUNT * ACTION_COUNT;
	localparam int unsigned DW    = $clog2(DEPTH);
	localparam int unsigned AW    = (ACTION_COUNT > 1) ? $clog2(ACTION_COUNT) : 1;
	localparam logic [DW-1:0] NA_D     = DW'(ACTION_COUNT);
	localparam logic [DW-1:0] LAST_ENT = DW'(DEPTH - 1);
	localparam logic [AW-1:0] LAST_ACT = AW'(ACTION_COUNT - 1);

	typedef enum logic [8:0] {
		ST_IDLE    = 9'b000000001,
		ST_SCAN    = 9'b000000010,
		ST_SEL_END = 9'b000000100,
		ST_RD_Q    = 9'b000001000,
		ST_MAC_T   = 9'b000010000,
		ST_MAC_Q   = 9'b000100000,
		ST_MAC_B   = 9'b001000000,
		ST_WB      = 9'b010000000,
		ST_CLEAR   = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [8:0]  learn_rate_q;
	logic [8:0]  discount_q;
	logic [15:0] explore_level_q;

	// command registers
	logic [1:0]         op_q;
	logic [5:0]         s_q;
	logic [1:0]         a_q;
	logic [5:0]         scan_st_q;
	logic signed [15:0] r_q;
	logic [15:0]        rnd_q;
	logic [1:0]         ract_q;

	// sequencing counters
	logic [AW-1:0] cnt_q;
	logic [DW-1:0] clr_q;
	logic          clr_res_q;

	// argmax tracking
	logic               pend_q;
	logic [AW-1:0]      pend_idx_q;
	logic signed [15:0] best_val_q;
	logic [AW-1:0]      best_idx_q;
	logic               take;
	logic signed [15:0] nb_val;
	logic [AW-1:0]      nb_idx;

	// update datapath
	logic signed [15:0]               q_q;
	logic signed [qtl_pkg::MUL_B_W-1:0] tgt_q;
	logic [8:0]                       beta;
	logic [8:0]                       gamma;
	logic signed [18:0]               v_flr;
	logic signed [15:0]               v_sat;

	// table ports
	logic          tbl_we;
	logic [DW-1:0] tbl_waddr;
	logic [15:0]   tbl_wdata;
	logic [DW-1:0] tbl_raddr;
	logic [15:0]   tbl_rdata;
	logic [DW-1:0] scan_addr;
	logic [DW-1:0] upd_addr;

	// multiply-accumulate ports
	qtl_pkg::mac_ctl_t                  mac_ctl;
	logic signed [qtl_pkg::MUL_A_W-1:0] mac_a;
	logic signed [qtl_pkg::MUL_B_W-1:0] mac_b;
	logic signed [qtl_pkg::ACC_W-1:0]   mac_add;
	logic signed [qtl_pkg::ACC_W-1:0]   mac_acc;

	logic accept;
	logic explore_hit;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q    <= qtl_pkg::LEARN_RATE_RST;
			discount_q      <= qtl_pkg::DISCOUNT_RST;
			explore_level_q <= qtl_pkg::EXPLORE_LEVEL_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				qtl_pkg::REG_LEARN_RATE:    learn_rate_q    <= cfg_data[8:0];
				qtl_pkg::REG_DISCOUNT:      discount_q      <= cfg_data[8:0];
				qtl_pkg::REG_EXPLORE_LEVEL: explore_level_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// rates above one clamp to one
	assign beta  = (learn_rate_q > qtl_pkg::RATE_ONE) ? qtl_pkg::RATE_ONE : learn_rate_q;
	assign gamma = (discount_q > qtl_pkg::RATE_ONE) ? qtl_pkg::RATE_ONE : discount_q;

	// table addressing
	assign scan_addr = DW'(scan_st_q) * NA_D + DW'(cnt_q);
	assign upd_addr  = DW'(s_q) * NA_D + DW'(a_q);

	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = clr_q;
		tbl_wdata = '0;
		tbl_raddr = scan_addr;
		if (state_q == ST_CLEAR) begin
			tbl_we = 1'b1;
		end
		if (state_q == ST_WB) begin
			tbl_we    = 1'b1;
			tbl_waddr = upd_addr;
			tbl_wdata = v_sat;
		end
		if (state_q == ST_RD_Q) begin
			tbl_raddr = upd_addr;
		end
	end

	qtl_table #(
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	// running argmax, lowest index wins ties
	assign take   = pend_q && ((pend_idx_q == '0) || ($signed(tbl_rdata) > best_val_q));
	assign nb_val = take ? $signed(tbl_rdata) : best_val_q;
	assign nb_idx = take ? pend_idx_q : best_idx_q;

	always_ff @(posedge clk) begin
		best_val_q <= nb_val;
		best_idx_q <= nb_idx;
		pend_idx_q <= cnt_q;
	end

	// multiply-accumulate schedule
	always_comb begin
		mac_ctl = '0;
		mac_a   = '0;
		mac_b   = '0;
		mac_add = '0;
		case (state_q)
			ST_MAC_T: begin
				// target = reward * 256 + gamma * maxQ(next)
				mac_ctl.en = 1'b1;
				mac_a      = qtl_pkg::MUL_A_W'(gamma);
				mac_b      = qtl_pkg::MUL_B_W'(best_val_q);
				mac_add    = {{(qtl_pkg::ACC_W - 24){r_q[15]}}, r_q, 8'd0};
			end
			ST_MAC_Q: begin
				// (1 - beta) * Q * 256
				mac_ctl.en = 1'b1;
				mac_a      = qtl_pkg::MUL_A_W'(qtl_pkg::RATE_ONE - beta);
				mac_b      = {{(qtl_pkg::MUL_B_W - 24){q_q[15]}}, q_q, 8'd0};
			end
			ST_MAC_B: begin
				// + beta * target
				mac_ctl.en    = 1'b1;
				mac_ctl.accum = 1'b1;
				mac_a         = qtl_pkg::MUL_A_W'(beta);
				mac_b         = tgt_q;
			end
			default: ;
		endcase
	end

	qtl_mac u_mac (
		.clk    (clk),
		.ctl    (mac_ctl),
		.mul_a  (mac_a),
		.mul_b  (mac_b),
		.addend (mac_add),
		.acc    (mac_acc)
	);

	// floor to Q8.8 and saturate
	assign v_flr = mac_acc[qtl_pkg::ACC_W-1:16];
	always_comb begin
		if (v_flr > 19'sd32767) begin
			v_sat = 16'sh7FFF;
		end else if (v_flr < -19'sd32768) begin
			v_sat = -16'sh8000;
		end else begin
			v_sat = v_flr[15:0];
		end
	end

	// datapath captures during an update
	always_ff @(posedge clk) begin
		if (state_q == ST_MAC_T) begin
			q_q <= $signed(tbl_rdata);
		end
		if (state_q == ST_MAC_Q) begin
			tgt_q <= mac_acc[qtl_pkg::MUL_B_W-1:0];
		end
	end

	// command capture with index reduction
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= action;
			s_q    <= qtl_pkg::reduce_idx(state_index, STATE_COUNT);
			a_q    <= 2'(qtl_pkg::reduce_idx({4'd0, act_index}, ACTION_COUNT));
			ract_q <= 2'(qtl_pkg::reduce_idx({4'd0, random_action}, ACTION_COUNT));
			r_q    <= reward_value;
			rnd_q  <= explore_draw;
			if (action == qtl_pkg::OP_SELECT) begin
				scan_st_q <= qtl_pkg::reduce_idx(state_index, STATE_COUNT);
			end else begin
				scan_st_q <= qtl_pkg::reduce_idx(next_state_index, STATE_COUNT);
			end
		end
	end

	assign explore_hit = (rnd_q > (16'hFFFF - explore_level_q));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			clr_q     <= '0;
			clr_res_q <= 1'b0;
			pend_q    <= 1'b0;
			done      <= 1'b0;
		end else begin
			done   <= 1'b0;
			pend_q <= (state_q == ST_SCAN);
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					clr_q <= '0;
					if (accept) begin
						case (action)
							qtl_pkg::OP_SELECT, qtl_pkg::OP_UPDATE: state_q <= ST_SCAN;
							qtl_pkg::OP_CLEAR: begin
								state_q   <= ST_CLEAR;
								clr_res_q <= 1'b1;
							end
							default: done <= 1'b1;
						endcase
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_ACT) begin
						state_q <= (op_q == qtl_pkg::OP_SELECT) ? ST_SEL_END : ST_RD_Q;
					end
				end
				ST_SEL_END: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				ST_RD_Q:  state_q <= ST_MAC_T;
				ST_MAC_T: state_q <= ST_MAC_Q;
				ST_MAC_Q: state_q <= ST_MAC_B;
				ST_MAC_B: state_q <= ST_WB;
				ST_WB: begin
					state_q <= ST_IDLE;
					done    <= 1'b1;
				end
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ENT) begin
						state_q   <= ST_IDLE;
						done      <= clr_res_q;
						clr_res_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SEL_END: begin
				q_result      <= nb_val;
				explored      <= explore_hit;
				chosen_action <= explore_hit ? ract_q : 2'(nb_idx);
			end
			ST_WB: begin
				q_result      <= v_sat;
				explored      <= 1'b0;
				chosen_action <= '0;
			end
			ST_IDLE, ST_CLEAR: begin
				q_result      <= '0;
				explored      <= 1'b0;
				chosen_action <= '0;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a result is shown only once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// every transfer either starts work or gives an immediate result
	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("transfer left no trace");

	// table writes come only from the clearing pass or the write-back
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_we |-> ((state_q == ST_CLEAR) || (state_q == ST_WB)))
		else $error("table write outside clear or write-back");

	// the beta pass follows the (1 - beta) pass
	a_mac_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC_B) |-> $past(state_q == ST_MAC_Q))
		else $error("multiply-accumulate passes out of order");
`endif

endmodule

`default_nettype wire

@@ tb/sv/q_table_learner_tb.sv @@
// ----------------------------------------------------------------------------
// q_table_learner_tb: self-checking bench for the Q-table learner
// Drives select, update, clear and reserved commands through the start/busy
// port, keeps its own copy of the Q table and rate registers, predicts each
// command's outcome at transfer and compares every done strobe against it.
// Directed tests cover threshold, tie, rounding, saturation and rate-clamp
// corners; three random phases follow with different sender idle rates.
// ----------------------------------------------------------------------------
`default_nettype none

module q_table_learner_tb;

	// codes with no name in the package
	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam logic [1:0] REG_UNUSED  = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         st;
		logic [1:0]         act;
		logic [5:0]         nst;
		logic signed [15:0] reward;
		logic [15:0]        rnd;
		logic [1:0]         rnd_act;
	} command_t;

	typedef struct packed {
		logic [1:0]         chosen;
		logic               expl;
		logic signed [15:0] q;
	} outcome_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         action;
	logic [5:0]         state_index;
	logic [1:0]         act_index;
	logic [5:0]         next_state_index;
	logic signed [15:0] reward_value;
	logic [15:0]        explore_draw;
	logic [1:0]         random_action;
	logic               done;
	logic [1:0]         chosen_action;
	logic               explored;
	logic signed [15:0] q_result;
	logic               cfg_write;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	// mirror of the block's table and registers
	logic signed [15:0] q_tbl [256];
	logic [8:0]         lr_reg;
	logic [8:0]         disc_reg;
	logic [15:0]        expl_reg;

	// outcomes of transferred commands, oldest first
	outcome_t           outcome_q [$];
	int                 mismatch_count;

	q_table_learner u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.state_index      (state_index),
		.act_index        (act_index),
		.next_state_index (next_state_index),
		.reward_value     (reward_value),
		.explore_draw     (explore_draw),
		.random_action    (random_action),
		.done             (done),
		.chosen_action    (chosen_action),
		.explored         (explored),
		.q_result         (q_result),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// argmax of a state row, lowest action wins ties
	function automatic int row_argmax(logic [5:0] st);
		int b;
		b = 0;
		for (int a = 1; a < 4; a++) begin
			if (q_tbl[int'(st) * 4 + a] > q_tbl[int'(st) * 4 + b]) begin
				b = a;
			end
		end
		return b;
	endfunction

	// advance the mirror by one command and return its outcome
	function automatic outcome_t learn_step(command_t c);
		outcome_t o;
		int       b;
		int       idx;
		longint   beta;
		longint   gamma;
		longint   q_old;
		longint   m;
		longint   target;
		longint   t;
		longint   v;
		o = '0;
		case (c.op)
			qtl_pkg::OP_SELECT: begin
				b = row_argmax(c.st);
				o.q = q_tbl[int'(c.st) * 4 + b];
				if (int'(c.rnd) > 65535 - int'(expl_reg)) begin
					o.chosen = c.rnd_act;
					o.expl   = 1'b1;
				end else begin
					o.chosen = 2'(b);
				end
			end
			qtl_pkg::OP_UPDATE: begin
				// rates above one clamp to one
				beta   = (lr_reg > qtl_pkg::RATE_ONE) ? 256 : longint'(lr_reg);
				gamma  = (disc_reg > qtl_pkg::RATE_ONE) ? 256 : longint'(disc_reg);
				idx    = int'(c.st) * 4 + int'(c.act);
				q_old  = longint'(q_tbl[idx]);
				m      = longint'(q_tbl[int'(c.nst) * 4 + row_argmax(c.nst)]);
				target = longint'(c.reward) * 256 + gamma * m;
				t      = (256 - beta) * q_old * 256 + beta * target;
				// arithmetic shift gives floor
				v      = t >>> 16;
				if (v > 32767) v = 32767;
				if (v < -32768) v = -32768;
				q_tbl[idx] = 16'(v);
				o.q = 16'(v);
			end
			qtl_pkg::OP_CLEAR: begin
				foreach (q_tbl[i]) q_tbl[i] = '0;
			end
			default: begin
			end
		endcase
		return o;
	endfunction

	function automatic command_t make_cmd(logic [1:0] op, logic [5:0] st, logic [1:0] act,
			logic [5:0] nst, logic signed [15:0] reward, logic [15:0] rnd,
			logic [1:0] rnd_act);
		command_t c;
		c = '{op, st, act, nst, reward, rnd, rnd_act};
		return c;
	endfunction

	// one command transfer; idle_pct is the per-cycle chance of a gap
	task automatic send_command(command_t c, int idle_pct);
		outcome_t o;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		action           = c.op;
		state_index      = c.st;
		act_index        = c.act;
		next_state_index = c.nst;
		reward_value     = c.reward;
		explore_draw     = c.rnd;
		random_action    = c.rnd_act;
		start            = 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);
		o = learn_step(c);
		outcome_q.push_back(o);
	endtask

	// stop sending and wait until every outcome is back and the block is free
	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (outcome_q.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic set_reg(logic [1:0] idx, logic [15:0] val);
		settle();
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_write = 1'b0;
		case (idx)
			qtl_pkg::REG_LEARN_RATE:    lr_reg   = val[8:0];
			qtl_pkg::REG_DISCOUNT:      disc_reg = val[8:0];
			qtl_pkg::REG_EXPLORE_LEVEL: expl_reg = val;
			default: begin
			end
		endcase
	endtask

	// compare each result with the oldest outstanding outcome
	always @(posedge clk) begin
		outcome_t o;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result with nothing outstanding: action %0d explored %0d q %0d",
					$time, chosen_action, explored, q_result);
				mismatch_count++;
			end else begin
				o = outcome_q.pop_front();
				if (chosen_action !== o.chosen) begin
					$display("%0t: chosen_action expected %0d got %0d",
						$time, o.chosen, chosen_action);
					mismatch_count++;
				end
				if (explored !== o.expl) begin
					$display("%0t: explored expected %0d got %0d", $time, o.expl, explored);
					mismatch_count++;
				end
				if (q_result !== o.q) begin
					$display("%0t: q_result expected %0d got %0d", $time, o.q, q_result);
					mismatch_count++;
				end
			end
		end
	end

	// empty table, default threshold: exploit at zero draw, explore at top draw
	task automatic test_zero_table();
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd0, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd0),
			0);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd63, 2'd0, 6'd0, 16'sd0, 16'hFFFF,
			2'd3), 0);
	endtask

	// threshold edges at the two extremes of the exploration level
	task automatic test_explore_threshold();
		set_reg(qtl_pkg::REG_EXPLORE_LEVEL, 16'hFFFF);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd5, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd2),
			0);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd5, 2'd0, 6'd0, 16'sd0, 16'd1, 2'd1),
			0);
		set_reg(qtl_pkg::REG_EXPLORE_LEVEL, 16'h0000);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd5, 2'd0, 6'd0, 16'sd0, 16'hFFFF,
			2'd3), 0);
	endtask

	// full rate and discount drive the update past both rails
	task automatic test_saturation();
		set_reg(qtl_pkg::REG_LEARN_RATE, 16'd256);
		set_reg(qtl_pkg::REG_DISCOUNT, 16'd256);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd0, 2'd0, 6'd0, 16'sh7FFF, 16'd0,
			2'd0), 0);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd0, 2'd0, 6'd0, 16'sh7FFF, 16'd0,
			2'd0), 0);
		for (int a = 0; a < 4; a++) begin
			send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd2, 2'(a), 6'd63, -16'sd32768,
				16'd0, 2'd0), 0);
		end
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd3, 2'd0, 6'd2, -16'sd32768, 16'd0,
			2'd0), 0);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd2, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd0),
			0);
	endtask

	// equal maxima pick the lower action; a negative half step floors down
	task automatic test_ties_and_rounding();
		set_reg(qtl_pkg::REG_LEARN_RATE, 16'd128);
		set_reg(qtl_pkg::REG_DISCOUNT, 16'd0);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd10, 2'd1, 6'd40, 16'sh0100, 16'd0,
			2'd0), 0);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd10, 2'd3, 6'd40, 16'sh0100, 16'd0,
			2'd0), 0);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd10, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd0),
			0);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd11, 2'd2, 6'd40, -16'sd1, 16'd0,
			2'd0), 0);
	endtask

	// rates above one act as one; the spare register index has no effect
	task automatic test_rate_limits();
		set_reg(qtl_pkg::REG_LEARN_RATE, 16'd511);
		set_reg(qtl_pkg::REG_DISCOUNT, 16'd300);
		send_command(make_cmd(qtl_pkg::OP_UPDATE, 6'd20, 2'd0, 6'd10, 16'sd1, 16'd0, 2'd0),
			0);
		set_reg(REG_UNUSED, 16'hFFFF);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd20, 2'd0, 6'd0, 16'sd0, 16'hFFFF,
			2'd0), 0);
	endtask

	// reserved operation returns zeros; clear empties the table
	task automatic test_reserved_and_clear();
		send_command(make_cmd(OP_RESERVED, 6'h3F, 2'd3, 6'h3F, -16'sd1, 16'hFFFF, 2'd3), 0);
		send_command(make_cmd(qtl_pkg::OP_CLEAR, 6'd0, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd0),
			0);
		send_command(make_cmd(qtl_pkg::OP_SELECT, 6'd0, 2'd0, 6'd0, 16'sd0, 16'd0, 2'd0),
			0);
	endtask

	// random command, biased toward a few hot states so values build up
	function automatic command_t random_command();
		command_t c;
		int       pick;
		int       th;
		pick = $urandom_range(99);
		if (pick < 46)      c.op = qtl_pkg::OP_SELECT;
		else if (pick < 94) c.op = qtl_pkg::OP_UPDATE;
		else if (pick < 97) c.op = qtl_pkg::OP_CLEAR;
		else                c.op = OP_RESERVED;
		c.st      = ($urandom_range(1) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		c.nst     = ($urandom_range(1) != 0) ? 6'($urandom_range(7)) : 6'($urandom_range(63));
		c.act     = 2'($urandom_range(3));
		c.rnd_act = 2'($urandom_range(3));
		case ($urandom_range(3))
			0: c.reward = 16'($urandom_range(65535));
			1: c.reward = 16'($urandom_range(1023)) - 16'sd512;
			2: c.reward = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
			default: c.reward = 16'($urandom_range(8191)) - 16'sd4096;
		endcase
		// draws just at and above the exploration threshold now and then
		th = 65535 - int'(expl_reg);
		if ($urandom_range(3) == 0) c.rnd = 16'(th + $urandom_range(1));
		else                        c.rnd = 16'($urandom_range(65535));
		return c;
	endfunction

	task automatic random_phase(int idle_pct, int count);
		for (int i = 0; i < count; i++) begin
			send_command(random_command(), idle_pct);
		end
	endtask

	// three random phases: light sender gaps, heavy gaps, none
	task automatic test_random_traffic();
		set_reg(qtl_pkg::REG_LEARN_RATE, 16'($urandom_range(16, 96)));
		set_reg(qtl_pkg::REG_DISCOUNT, 16'($urandom_range(128, 256)));
		set_reg(qtl_pkg::REG_EXPLORE_LEVEL, 16'($urandom_range(1000, 20000)));
		random_phase(30, 370);

		case ($urandom_range(2))
			0: set_reg(qtl_pkg::REG_LEARN_RATE, 16'd0);
			1: set_reg(qtl_pkg::REG_LEARN_RATE, 16'd256);
			default: set_reg(qtl_pkg::REG_LEARN_RATE, 16'h01FF);
		endcase
		set_reg(qtl_pkg::REG_DISCOUNT, ($urandom_range(1) != 0) ? 16'd256 : 16'hFE00);
		set_reg(qtl_pkg::REG_EXPLORE_LEVEL, ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000);
		random_phase(72, 370);

		set_reg(qtl_pkg::REG_LEARN_RATE, 16'($urandom_range(65535)));
		set_reg(qtl_pkg::REG_DISCOUNT, 16'($urandom_range(65535)));
		set_reg(qtl_pkg::REG_EXPLORE_LEVEL, 16'($urandom_range(65535)));
		random_phase(0, 370);
	endtask

	initial begin
		arst_n           = 1'b0;
		start            = 1'b0;
		action           = qtl_pkg::OP_SELECT;
		state_index      = '0;
		act_index        = '0;
		next_state_index = '0;
		reward_value     = '0;
		explore_draw     = '0;
		random_action    = '0;
		cfg_write        = 1'b0;
		cfg_index        = qtl_pkg::REG_LEARN_RATE;
		cfg_data         = '0;
		lr_reg           = qtl_pkg::LEARN_RATE_RST;
		disc_reg         = qtl_pkg::DISCOUNT_RST;
		expl_reg         = qtl_pkg::EXPLORE_LEVEL_RST;
		mismatch_count   = 0;
		foreach (q_tbl[i]) q_tbl[i] = '0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_zero_table();
		test_explore_threshold();
		test_saturation();
		test_ties_and_rounding();
		test_rate_limits();
		test_reserved_and_clear();
		test_random_traffic();

		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
